[hw/rtl/bba_pkg.sv]
// Shared types and codes for the bitmap block allocator.
`timescale 1ns / 1ps

package bba_pkg;

  // Request operations
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Register indexes on the configuration port
  localparam logic [0:0] REG_TOTAL_BLOCKS = 1'b0;

  // Reset value of total_blocks
  localparam logic [12:0] TOTAL_RESET = 13'd4096;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] block_number;
    logic        write_value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] result_block;
    logic        bit_value;
    logic [12:0] free_count;
  } out_rsp_t;

endpackage

[hw/rtl/bitmap_block_allocator.sv]
// Top level of the first-fit bitmap block allocator.
// Flow: a range error or a zero-count allocate goes from acceptance to S_DONE and the result
// register; a free, read or write passes S_RMW, then S_DONE; an allocate reads one map word per
// S_SCAN step, as the map memory has a single read port, scanning up to ceil(total/WORD_BITS)
// words (64 at the defaults). One request in flight; result stalls hold off the next one.
// Reset: a clearing pass writes all MAP_WORDS map words (64 at the defaults), stalls input.
`timescale 1ns / 1ps

module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  bba_pkg::in_req_t  in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output bba_pkg::out_rsp_t out_data,
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  // Clamp a programmed total to the map size.
  function automatic logic [12:0] clamp_total(input logic [12:0] t);
    clamp_total = (32'(t) > 32'(MAX_BLOCKS)) ? 13'(MAX_BLOCKS) : t;
  endfunction

  logic [12:0]          total_r;
  logic [12:0]          total_nxt;
  logic [12:0]          total_eff;
  logic [12:0]          total_reload;
  logic                 reg_hit;
  logic                 total_load;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  // Register decode: word index sits above the byte offset.
  assign reg_hit    = (cfg_paddr[2:2] == bba_pkg::REG_TOTAL_BLOCKS);
  assign total_load = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_hit ? {19'd0, total_r} : 32'd0;

  // A write to total_blocks also reloads the free count with the clamped total.
  assign total_nxt    = total_load ? cfg_pwdata[12:0] : total_r;
  assign total_reload = clamp_total(cfg_pwdata[12:0]);
  assign total_eff    = clamp_total(total_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= bba_pkg::TOTAL_RESET;
    end else begin
      total_r <= total_nxt;
    end
  end

  // Sequencer: owns the free count, the scan pointer and the result register.
  bba_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .total_eff    (total_eff),
    .total_load   (total_load),
    .total_reload (total_reload),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  // Occupancy map: one word of WORD_BITS blocks per entry.
  bba_map_mem #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

`ifndef NO_ASSERTIONS
  // The free count never exceeds the managed total.
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.free_count <= total_eff))
    else $error("free count above managed total");

  // A range error only reports block numbers at or above the total.
  a_range_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == bba_pkg::ST_RANGE) |->
      ({1'b0, out_data.result_block} >= total_eff))
    else $error("range error on an in-range block");

  // A failed allocate reports block zero and no bit.
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == bba_pkg::ST_FULL) |->
      (out_data.result_block == 12'd0 && !out_data.bit_value))
    else $error("failed allocate carries a block");
`endif

endmodule

[hw/rtl/bba_map_mem.sv]
// Occupancy map storage: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module bba_map_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/bba_ctrl.sv]
// Request sequencer: map clear, first-fit word scan, read-modify-write, result register.
`timescale 1ns / 1ps

module bba_ctrl #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 64,
  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS,
  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
  localparam int BW = $clog2(WORD_BITS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bba_pkg::in_req_t     in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bba_pkg::out_rsp_t    out_data,
  input  logic [12:0]          total_eff,
  input  logic                 total_load,
  input  logic [12:0]          total_reload,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [WORD_BITS-1:0] mem_wdata,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  input  logic [WORD_BITS-1:0] mem_rdata
);

  localparam logic [12:0] FREE_RESET =
    (MAX_BLOCKS < 4096) ? 13'(MAX_BLOCKS) : bba_pkg::TOTAL_RESET;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RMW,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [11:0]       blk_r, blk_nxt;
  logic              wv_r, wv_nxt;
  logic [AW-1:0]     scan_r, scan_nxt;
  logic [AW-1:0]     last_word_r, last_word_nxt;
  logic [BW:0]       last_cnt_r, last_cnt_nxt;
  logic [12:0]       free_r, free_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [11:0]       res_r, res_nxt;
  logic              bitv_r, bitv_nxt;
  logic              out_valid_r, out_valid_nxt;
  bba_pkg::out_rsp_t out_data_r, out_data_nxt;

  logic [AW-1:0]        in_word;
  logic [AW-1:0]        blk_word;
  logic [BW-1:0]        blk_bit;
  logic [WORD_BITS-1:0] blk_oh;
  logic [WORD_BITS-1:0] tail_mask;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] low_bit;
  logic [BW-1:0]        low_idx;

  assign in_word  = AW'(32'(in_data.block_number) / WORD_BITS);
  assign blk_word = AW'(32'(blk_r) / WORD_BITS);
  assign blk_bit  = BW'(32'(blk_r) % WORD_BITS);
  assign blk_oh   = WORD_BITS'(1) << blk_bit;

  // Lowest clear bit of the scanned word, limited to blocks below the total
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      tail_mask[j] = (scan_r != last_word_r) || (32'(j) < 32'(last_cnt_r));
    end
  end

  assign cand    = ~mem_rdata & tail_mask;
  assign low_bit = cand & (~cand + WORD_BITS'(1));

  always_comb begin
    low_idx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (low_bit[j]) begin
        low_idx = low_idx | BW'(j);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    blk_nxt       = blk_r;
    wv_nxt        = wv_r;
    scan_nxt      = scan_r;
    last_word_nxt = last_word_r;
    last_cnt_nxt  = last_cnt_r;
    free_nxt      = free_r;
    st_nxt        = st_r;
    res_nxt       = res_r;
    bitv_nxt      = bitv_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = in_word;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_data.operation;
          blk_nxt  = in_data.block_number;
          wv_nxt   = in_data.write_value;
          bitv_nxt = 1'b0;
          if (in_data.operation == bba_pkg::OP_ALLOC) begin
            if (free_r == '0) begin
              st_nxt    = bba_pkg::ST_FULL;
              res_nxt   = '0;
              state_nxt = S_DONE;
            end else begin
              mem_re        = 1'b1;
              mem_raddr     = '0;
              scan_nxt      = '0;
              last_word_nxt = AW'((32'(total_eff) - 32'd1) / WORD_BITS);
              last_cnt_nxt  = (BW+1)'((32'(total_eff) - 32'd1) % WORD_BITS + 32'd1);
              state_nxt     = S_SCAN;
            end
          end else if ({1'b0, in_data.block_number} >= total_eff) begin
            st_nxt    = bba_pkg::ST_RANGE;
            res_nxt   = in_data.block_number;
            state_nxt = S_DONE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = in_word;
            state_nxt = S_RMW;
          end
        end
      end

      S_SCAN: begin
        if (cand != '0) begin
          mem_we    = 1'b1;
          mem_waddr = scan_r;
          mem_wdata = mem_rdata | low_bit;
          free_nxt  = free_r - 13'd1;
          st_nxt    = bba_pkg::ST_OK;
          res_nxt   = 12'(32'(scan_r) * WORD_BITS + 32'(low_idx));
          state_nxt = S_DONE;
        end else if (scan_r == last_word_r) begin
          st_nxt    = bba_pkg::ST_FULL;
          res_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = scan_r + AW'(1);
          scan_nxt  = scan_r + AW'(1);
        end
      end

      S_RMW: begin
        st_nxt    = bba_pkg::ST_OK;
        res_nxt   = blk_r;
        state_nxt = S_DONE;
        mem_waddr = blk_word;
        case (op_r)
          bba_pkg::OP_FREE: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata & ~blk_oh;
            if (free_r < total_eff) begin
              free_nxt = free_r + 13'd1;
            end
          end
          bba_pkg::OP_READ: begin
            bitv_nxt = mem_rdata[blk_bit];
          end
          default: begin
            mem_we    = 1'b1;
            mem_wdata = wv_r ? (mem_rdata | blk_oh) : (mem_rdata & ~blk_oh);
          end
        endcase
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: st_r, result_block: res_r,
                            bit_value: bitv_r, free_count: free_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (total_load) begin
      free_nxt = total_reload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      free_r      <= FREE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    blk_r       <= blk_nxt;
    wv_r        <= wv_nxt;
    scan_r      <= scan_nxt;
    last_word_r <= last_word_nxt;
    last_cnt_r  <= last_cnt_nxt;
    st_r        <= st_nxt;
    res_r       <= res_nxt;
    bitv_r      <= bitv_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
